### rtl/tkt_pkg.sv
// Package for the top-k tracker: sizes, the kept entry type and the cell control type.
package tkt_pkg;

    localparam int TOP_K         = 10;
    localparam int POSITION_BITS = 16;
    localparam int VALUE_W       = 32;
    localparam int INDEX_W       = 16;

    typedef logic [VALUE_W-1:0]       value_t;
    typedef logic [INDEX_W-1:0]       index_t;
    typedef logic [POSITION_BITS-1:0] position_t;

    // One kept entry of the ranked list.
    typedef struct packed {
        logic   valid;
        value_t value;
        index_t index;
    } entry_t;

    // Cell control, shared by every cell of the chain.
    typedef struct packed {
        logic take;      // insert the broadcast sample this cycle
        logic shift_up;  // advance the list one cell toward the head
    } cell_ctrl_t;

    // Low index bits of a stream position, zero extended when the position is narrow.
    function automatic index_t position_to_index(input position_t pos);
        logic [63:0] wide;
        wide = 64'(pos);
        return wide[INDEX_W-1:0];
    endfunction

endpackage

### rtl/tkt_cell.sv
// One cell of the sorted insertion chain: holds one kept entry.
module tkt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  tkt_pkg::cell_ctrl_t ctrl,
    input  tkt_pkg::entry_t     sample,
    input  logic                prev_ins,
    input  tkt_pkg::entry_t     prev_entry,
    input  tkt_pkg::entry_t     next_entry,
    output logic                ins,
    output tkt_pkg::entry_t     entry
);

    tkt_pkg::entry_t entry_reg;
    tkt_pkg::entry_t entry_next;

    // Sample belongs here or above when this slot is empty or strictly beaten.
    assign ins   = !entry_reg.valid || (sample.value > entry_reg.value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.take)
        begin
            // Shift down when the sample lands above, take it when it lands here.
            priority if (prev_ins)
            begin
                entry_next = prev_entry;
            end
            else if (ins)
            begin
                entry_next = sample;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
        else if (ctrl.shift_up)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### rtl/top_k_max_tracker_top.sv
// Top level of the top-k tracker: a chain of sorting cells plus the readout control.
// Throughput: one sample per cycle while collecting; the readout of N kept entries
// takes N output transfers, during which no sample is accepted.
// A sample enters the cell chain at its transfer edge; after a last sample
// the first ranked entry is offered on the next cycle.
// Reset (rst_n low, asynchronous) empties every cell and zeroes the position count.
module top_k_max_tracker_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_value,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] ranked_value,
    output logic [15:0] ranked_index,
    output logic        out_last
);

    // Chain links: element 0 and element TOP_K+1 are empty bookends, cell i
    // drives element i+1.
    tkt_pkg::entry_t     cell_q [tkt_pkg::TOP_K+2];
    logic                ins_q  [tkt_pkg::TOP_K+1];
    tkt_pkg::entry_t     sample;
    tkt_pkg::cell_ctrl_t ctrl;

    logic                drain_reg;
    logic                drain_next;
    tkt_pkg::position_t  pos_reg;
    tkt_pkg::position_t  pos_next;

    logic in_xfer;
    logic out_xfer;

    // Hold off new samples for the whole readout.
    assign in_stall = drain_reg;
    assign in_xfer  = in_valid && !drain_reg;

    // The head cell is the output register; its payload holds while stalled.
    assign out_valid    = drain_reg && cell_q[1].valid;
    assign ranked_value = cell_q[1].value;
    assign ranked_index = cell_q[1].index;
    assign out_last     = !cell_q[2].valid;
    assign out_xfer     = out_valid && !out_stall;

    // Broadcast the incoming sample with its stream position.
    assign sample.valid = 1'b1;
    assign sample.value = sample_value;
    assign sample.index = tkt_pkg::position_to_index(pos_reg);

    assign ctrl.take     = in_xfer;
    assign ctrl.shift_up = out_xfer;

    assign cell_q[0]                  = '0;
    assign cell_q[tkt_pkg::TOP_K + 1] = '0;
    assign ins_q[0]                   = 1'b0;

    for (genvar i = 0; i < tkt_pkg::TOP_K; i++)
    begin : g_cell
        tkt_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (sample),
            .prev_ins   (ins_q[i]),
            .prev_entry (cell_q[i]),
            .next_entry (cell_q[i+2]),
            .ins        (ins_q[i+1]),
            .entry      (cell_q[i+1])
        );
    end

    // Advance the position per sample; enter readout after a last sample and
    // drop back to the reset state once the final entry has gone out.
    always_comb
    begin
        drain_next = drain_reg;
        pos_next   = pos_reg;
        priority if (in_xfer)
        begin
            pos_next = pos_reg + 1'b1;
            if (in_last)
            begin
                drain_next = 1'b1;
            end
        end
        else if (out_xfer && out_last)
        begin
            drain_next = 1'b0;
            pos_next   = '0;
        end
        else
        begin
            drain_next = drain_reg;
            pos_next   = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            drain_reg <= drain_next;
            pos_reg   <= pos_next;
        end
    end

    // A readout always has an entry at the head.
    a_drain_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> cell_q[1].valid)
        else $error("readout active with an empty head cell");

    // Filled cells form a prefix of the chain.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_q[1].valid |-> !cell_q[2].valid)
        else $error("gap in the kept list");

    // A last sample starts the readout.
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_last) |=> drain_reg)
        else $error("readout did not start after a last sample");

    // The final ranked transfer returns the block to its reset state.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && out_last) |=> (!drain_reg && pos_reg == '0 && !cell_q[1].valid))
        else $error("block not cleared after the readout");

endmodule
